>>> design/gif_lzw_code_stream_encoder_macros.svh
// Assertion macros used by the encoder's top-level RTL file.
`ifndef GIF_LZW_CODE_STREAM_ENCODER_MACROS_SVH
`define GIF_LZW_CODE_STREAM_ENCODER_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define GLCSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, during reset as well.
`define GLCSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> design/glcse_pkg.sv
// ----------------------------------------------------------------------------
// glcse_pkg
// Types, constants and the hash function of the LZW code stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package glcse_pkg;

  localparam int DICT_ENTRIES = 8192;
  localparam int MAX_CODE     = 4095;
  localparam int DICT_AW      = $clog2(DICT_ENTRIES);

  localparam int KEY_W   = 20;
  localparam int CODE_W  = 12;
  localparam int CUR_W   = 13;
  localparam int EP_W    = 4;
  localparam int ACC_W   = 20;
  localparam int CNT_W   = 5;
  localparam int CW_W    = 4;
  localparam int LIM_W   = 14;

  localparam logic [CODE_W-1:0] CLR_CODE    = 12'd256;
  localparam logic [CODE_W-1:0] END_CODE    = 12'd257;
  localparam logic [CUR_W-1:0]  FIRST_FREE  = 13'd258;
  localparam logic [CUR_W-1:0]  NO_CODE     = 13'd4097;
  localparam logic [CUR_W-1:0]  MAX_CODE_V  = CUR_W'(MAX_CODE);
  localparam logic [CW_W-1:0]   START_WIDTH = 4'd9;
  localparam logic [CW_W-1:0]   TOP_WIDTH   = 4'd12;
  localparam logic [LIM_W-1:0]  START_LIMIT = 14'd512;

  // One dictionary slot; a slot is live only when its epoch matches.
  typedef struct packed {
    logic [EP_W-1:0]   epoch;
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
  } dict_entry_t;

  // Home slot of a key: fold the upper bits onto the lower ones.
  function automatic logic [DICT_AW-1:0] hash_of(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] folded;
    folded = key ^ (key >> 12);
    return folded[DICT_AW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/glcse_dict.sv
// ----------------------------------------------------------------------------
// glcse_dict
// Dictionary memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module glcse_dict
  import glcse_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rd_en_i,
  input  wire logic [DICT_AW-1:0] rd_addr_i,
  input  wire logic               wr_en_i,
  input  wire logic [DICT_AW-1:0] wr_addr_i,
  input  wire dict_entry_t        wr_data_i,
  output dict_entry_t             rd_data_o
);

  dict_entry_t mem_q [DICT_ENTRIES];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/gif_lzw_code_stream_encoder.sv
// ----------------------------------------------------------------------------
// gif_lzw_code_stream_encoder
// LZW encoder for GIF pixel data with variable code width and byte packing.
// ----------------------------------------------------------------------------
// Usage: one pixel transaction (pixel_index_i, frame_end_i) enters on the
// in_valid_i/in_ready_o channel; the packed code stream leaves one byte per
// transaction on out_valid_o/out_ready_i. run_last_o marks the last byte that
// a pixel caused, frame_done_o the final flushed byte of a frame.
// One pixel is handled at a time by a sequencer around the dictionary memory
// and a single bit packer. A dictionary probe reads a slot, then compares it;
// each emitted code is packed, then drained one completed byte at a time.
// The registered read port of the memory paces the probes. After reset, and
// after every fifteenth dictionary restart (a clear code or a frame end), the
// block sweeps all 8192 dictionary entries with in_ready_o low.
// When the receiver stalls, at most one byte waits in the output register and
// one in a holding register; the sequencer then waits until it drains.
// The end of a frame resets the code, width and packer state, and steps the
// epoch or schedules a sweep.
`default_nettype none

`include "gif_lzw_code_stream_encoder_macros.svh"

module gif_lzw_code_stream_encoder
  import glcse_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] pixel_index_i,
  input  wire logic       frame_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      code_byte_o,
  output logic            run_last_o,
  output logic            frame_done_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_CMP, S_PUT, S_DRAIN, S_MISS,
    S_AFTER, S_FLUSH, S_FINISH, S_SWEEP
  } state_e;

  typedef enum logic [2:0] {
    R_FIRST, R_MISS, R_FULL, R_LAST1, R_LAST2
  } ret_e;

  state_e             state_q;
  ret_e               ret_q;
  logic [7:0]         pix_q;
  logic               last_q;
  logic [CUR_W-1:0]   cur_q;
  logic [CUR_W-1:0]   nfc_q;
  logic [CW_W-1:0]    cw_q;
  logic [LIM_W-1:0]   lim_q;
  logic [ACC_W-1:0]   acc_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CODE_W-1:0]  code_q;
  logic [DICT_AW-1:0] addr_q;
  logic [KEY_W-1:0]   key_q;
  logic [EP_W-1:0]    ep_q;
  logic               sweep_q;
  logic               pend_v_q;
  logic [7:0]         pend_q;

  dict_entry_t rd_data;
  dict_entry_t wr_data;
  logic        dict_wr_en;
  logic        slot_live;
  logic        out_free;
  logic        widen;
  logic        dict_full;
  logic        load_out;

  // Dictionary memory.
  glcse_dict u_dict (
    .clk_i     (clk_i),
    .rd_en_i   (state_q == S_PROBE),
    .rd_addr_i (addr_q),
    .wr_en_i   (dict_wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // Helper decodes for the sequencer.
  assign dict_full  = (nfc_q >= MAX_CODE_V);
  assign dict_wr_en = (state_q == S_SWEEP) || ((state_q == S_MISS) && !dict_full);
  always_comb begin
    wr_data = '0;
    if (state_q != S_SWEEP) begin
      wr_data.epoch = ep_q;
      wr_data.key   = key_q;
      wr_data.code  = nfc_q[CODE_W-1:0];
    end
  end
  assign slot_live  = (rd_data.epoch == ep_q);
  assign out_free   = !out_valid_o || out_ready_i;
  assign widen      = ({1'b0, nfc_q} >= lim_q) && (cw_q < TOP_WIDTH);
  assign in_ready_o = (state_q == S_IDLE);

  // The holding register passes its byte to the output register this cycle.
  assign load_out = pend_v_q && out_free &&
                    (((state_q == S_DRAIN) && (cnt_q >= CNT_W'(8))) ||
                     ((state_q == S_FLUSH) && (cnt_q != '0)) ||
                     (state_q == S_FINISH));

  // Sequencer, bit packer and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      ret_q       <= R_FIRST;
      last_q      <= 1'b0;
      cur_q       <= NO_CODE;
      nfc_q       <= FIRST_FREE;
      cw_q        <= START_WIDTH;
      lim_q       <= START_LIMIT;
      acc_q       <= '0;
      cnt_q       <= '0;
      addr_q      <= '0;
      ep_q        <= EP_W'(1);
      sweep_q     <= 1'b1;
      pend_v_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pix_q  <= pixel_index_i;
            last_q <= frame_end_i;
            if (cur_q == NO_CODE) begin
              code_q  <= CLR_CODE;
              cur_q   <= {5'b0, pixel_index_i};
              ret_q   <= R_FIRST;
              state_q <= S_PUT;
            end else begin
              key_q   <= {cur_q[CODE_W-1:0], pixel_index_i};
              addr_q  <= hash_of({cur_q[CODE_W-1:0], pixel_index_i});
              state_q <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          priority if (slot_live && (rd_data.key == key_q)) begin
            cur_q   <= {1'b0, rd_data.code};
            state_q <= S_AFTER;
          end else if (!slot_live) begin
            code_q  <= cur_q[CODE_W-1:0];
            cur_q   <= {5'b0, pix_q};
            ret_q   <= R_MISS;
            state_q <= S_PUT;
          end else begin
            addr_q  <= addr_q + 1'b1;
            state_q <= S_PROBE;
          end
        end
        S_PUT: begin
          acc_q   <= acc_q | (ACC_W'(code_q) << cnt_q[2:0]);
          cnt_q   <= cnt_q + CNT_W'(cw_q);
          state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (cnt_q >= CNT_W'(8)) begin
            // Hand a completed byte to the holding register.
            if (!pend_v_q || out_free) begin
              if (pend_v_q) begin
                code_byte_o  <= pend_q;
                run_last_o   <= 1'b0;
                frame_done_o <= 1'b0;
              end
              pend_v_q <= 1'b1;
              pend_q   <= acc_q[7:0];
              acc_q    <= acc_q >> 8;
              cnt_q    <= cnt_q - CNT_W'(8);
            end
          end else begin
            // A clear restarts the width, so widening only applies otherwise.
            if (widen && (ret_q != R_FULL)) begin
              cw_q  <= cw_q + 1'b1;
              lim_q <= lim_q << 1;
            end
            unique case (ret_q)
              R_FIRST: state_q <= S_AFTER;
              R_MISS:  state_q <= S_MISS;
              R_FULL: begin
                nfc_q <= FIRST_FREE;
                cw_q  <= START_WIDTH;
                lim_q <= START_LIMIT;
                if (!sweep_q) begin
                  if (&ep_q) sweep_q <= 1'b1;
                  else       ep_q    <= ep_q + 1'b1;
                end
                state_q <= S_AFTER;
              end
              R_LAST1: begin
                code_q  <= END_CODE;
                ret_q   <= R_LAST2;
                state_q <= S_PUT;
              end
              R_LAST2: state_q <= S_FLUSH;
              default: state_q <= S_FLUSH;
            endcase
          end
        end
        S_MISS: begin
          if (dict_full) begin
            code_q  <= CLR_CODE;
            ret_q   <= R_FULL;
            state_q <= S_PUT;
          end else begin
            nfc_q   <= nfc_q + 1'b1;
            state_q <= S_AFTER;
          end
        end
        S_AFTER: begin
          if (last_q) begin
            code_q  <= cur_q[CODE_W-1:0];
            ret_q   <= R_LAST1;
            state_q <= S_PUT;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_FLUSH: begin
          if ((cnt_q == '0) || !pend_v_q || out_free) begin
            if (cnt_q != '0) begin
              if (pend_v_q) begin
                code_byte_o  <= pend_q;
                run_last_o   <= 1'b0;
                frame_done_o <= 1'b0;
              end
              pend_v_q <= 1'b1;
              pend_q   <= acc_q[7:0];
            end
            // Frame complete: return the code, width and packer state to reset values.
            cur_q <= NO_CODE;
            acc_q <= '0;
            cnt_q <= '0;
            nfc_q <= FIRST_FREE;
            cw_q  <= START_WIDTH;
            lim_q <= START_LIMIT;
            if (!sweep_q) begin
              if (&ep_q) sweep_q <= 1'b1;
              else       ep_q    <= ep_q + 1'b1;
            end
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              code_byte_o  <= pend_q;
              run_last_o   <= 1'b1;
              frame_done_o <= last_q;
              pend_v_q     <= 1'b0;
            end
            addr_q  <= '0;
            state_q <= sweep_q ? S_SWEEP : S_IDLE;
          end
        end
        S_SWEEP: begin
          // Stamp every slot with the retired epoch zero.
          addr_q <= addr_q + 1'b1;
          if (&addr_q) begin
            sweep_q <= 1'b0;
            ep_q    <= EP_W'(1);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The holding register is always emptied before the next pixel is taken.
  `GLCSE_ASSERT(a_idle_no_pending, in_ready_o |-> !pend_v_q, "byte left pending at idle")
  // Fewer than eight bits wait between pixels.
  `GLCSE_ASSERT(a_idle_cnt, in_ready_o |-> (cnt_q < CNT_W'(8)), "bit count too large at idle")
  // Code width stays within nine to twelve bits.
  `GLCSE_ASSERT(a_width_range, (cw_q >= START_WIDTH) && (cw_q <= TOP_WIDTH), "bad code width")
  // The frame's final byte is also the last byte of its pixel.
  `GLCSE_ASSERT(a_done_last, (out_valid_o && frame_done_o) |-> run_last_o, "frame_done without run_last")
  // No lookup is attempted while a sweep is owed.
  `GLCSE_ASSERT(a_probe_clean, (state_q == S_PROBE) |-> !sweep_q, "probe during pending sweep")

endmodule

`default_nettype wire

>>> verif/tb_gif_lzw_code_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gif_lzw_code_stream_encoder
// Self-checking bench for the GIF LZW code stream encoder. A software copy of
// the encoder (hash dictionary, code widening, LSB-first packing) predicts the
// bytes of every pixel transaction; each output transaction is compared with
// the oldest prediction. Frames of varied length are driven with bursty input
// and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gif_lzw_code_stream_encoder
  import glcse_pkg::*;
();

  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_done;
  } code_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] pixel_index_i = '0;
  logic       frame_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] code_byte_o;
  logic       run_last_o;
  logic       frame_done_o;

  gif_lzw_code_stream_encoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_index_i(pixel_index_i),
    .frame_end_i  (frame_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_byte_o  (code_byte_o),
    .run_last_o   (run_last_o),
    .frame_done_o (frame_done_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state.
  logic        slot_used [DICT_ENTRIES];
  logic [19:0] slot_key  [DICT_ENTRIES];
  logic [11:0] slot_code [DICT_ENTRIES];
  int unsigned cur_code, free_code, width, limit, acc, nbits;

  pixel_t     pixel_queue[$];
  code_byte_t byte_queue[$];
  code_byte_t step_bytes[$];
  int errors = 0;
  int pixels_sent = 0;
  int bytes_seen = 0;
  int frames_seen = 0;
  int idle_cycles = 0;

  function automatic int unsigned home_slot(int unsigned key);
    return ((key >> 12) ^ key) & (DICT_ENTRIES - 1);
  endfunction

  // Append one pixel to the stimulus queue.
  task automatic queue_pixel(logic [7:0] pix, logic last);
    pixel_t p;
    p.pixel = pix;
    p.last = last;
    pixel_queue = {pixel_queue, p};
  endtask

  // Append one predicted byte of the current pixel.
  task automatic queue_step_byte(logic [7:0] b);
    code_byte_t cb;
    cb.data = b;
    cb.run_last = 1'b0;
    cb.frame_done = 1'b0;
    step_bytes = {step_bytes, cb};
  endtask

  task automatic restart_dict();
    free_code = FIRST_FREE;
    width = START_WIDTH;
    limit = 1 << START_WIDTH;
    for (int i = 0; i < DICT_ENTRIES; i++) slot_used[i] = 1'b0;
  endtask

  task automatic encoder_reset();
    restart_dict();
    cur_code = NO_CODE;
    acc = 0;
    nbits = 0;
  endtask

  task automatic pack_code(int unsigned code);
    acc |= (code & 12'hFFF) << nbits;
    nbits += width;
    while (nbits >= 8) begin
      queue_step_byte(acc[7:0]);
      acc >>= 8;
      nbits -= 8;
    end
    if (free_code >= limit && width < TOP_WIDTH) begin
      width++;
      limit = 1 << width;
    end
  endtask

  // Work out the bytes one pixel causes and queue them as expectations.
  task automatic predict_pixel(pixel_t p);
    int unsigned key, pos;
    int found;
    step_bytes.delete();
    if (cur_code == NO_CODE) begin
      pack_code(CLR_CODE);
      cur_code = p.pixel;
    end else begin
      key = ((cur_code & 12'hFFF) << 8) | p.pixel;
      pos = home_slot(key);
      found = -1;
      for (int n = 0; n < DICT_ENTRIES; n++) begin
        if (!slot_used[pos]) break;
        if (slot_key[pos] == key) begin
          found = slot_code[pos];
          break;
        end
        pos = (pos + 1) % DICT_ENTRIES;
      end
      if (found >= 0) begin
        cur_code = found;
      end else begin
        pack_code(cur_code);
        cur_code = p.pixel;
        if (free_code >= MAX_CODE) begin
          pack_code(CLR_CODE);
          restart_dict();
        end else begin
          // The probe stopped on the first free slot.
          if (!slot_used[pos]) begin
            slot_used[pos] = 1'b1;
            slot_key[pos] = key;
            slot_code[pos] = free_code;
          end
          free_code++;
        end
      end
    end
    if (p.last) begin
      pack_code(cur_code);
      pack_code(END_CODE);
      if (nbits > 0) queue_step_byte(acc[7:0]);
      encoder_reset();
    end
    if (step_bytes.size() > 0) begin
      step_bytes[step_bytes.size()-1].run_last = 1'b1;
      step_bytes[step_bytes.size()-1].frame_done = p.last;
    end
    foreach (step_bytes[i]) byte_queue = {byte_queue, step_bytes[i]};
  endtask

  // Frame generator: the palette depth sets how soon the dictionary fills.
  task automatic add_frame(int len, int unsigned depth);
    pixel_t p;
    for (int i = 0; i < len; i++) begin
      p.pixel = (depth >= 256) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, depth - 1));
      p.last = (i == len - 1);
      pixel_queue = {pixel_queue, p};
    end
  endtask

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_pixel('{pixel: pixel_index_i, last: frame_end_i});
        pixels_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pixel_queue.size() > 0) begin
          pixel_t p;
          p = pixel_queue.pop_front();
          pixel_index_i <= p.pixel;
          frame_end_i <= p.last;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern and output checker.
  int unsigned stall_phase = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      code_byte_t exp_b;
      stall_phase <= stall_phase + 1;
      out_ready_i <= (stall_phase[9:8] == 2'd0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (out_valid_o && out_ready_i) begin
        bytes_seen++;
        if (frame_done_o) frames_seen++;
        if (byte_queue.size() == 0) begin
          $display("%0t: unexpected byte %h run_last %b frame_done %b", $time,
                   code_byte_o, run_last_o, frame_done_o);
          errors++;
        end else begin
          exp_b = byte_queue.pop_front();
          if (exp_b.data !== code_byte_o)
            $display("%0t: code_byte expected %h actual %h", $time, exp_b.data, code_byte_o);
          if (exp_b.run_last !== run_last_o)
            $display("%0t: run_last expected %b actual %b", $time, exp_b.run_last, run_last_o);
          if (exp_b.frame_done !== frame_done_o)
            $display("%0t: frame_done expected %b actual %b", $time, exp_b.frame_done,
                     frame_done_o);
          if (exp_b !== {code_byte_o, run_last_o, frame_done_o}) errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 40000) begin
        $display("tb_gif_lzw_code_stream_encoder failed");
        $finish;
      end
    end
  end

  initial begin
    encoder_reset();
    // Directed: single-pixel frames at both extremes and a run of repeats.
    queue_pixel(8'hFF, 1'b1);
    queue_pixel(8'h00, 1'b1);
    for (int i = 0; i < 4; i++) queue_pixel(8'hAA, (i == 3));
    // Short frames that step the epoch to its last value, so the next frame end sweeps.
    for (int i = 0; i < 11; i++) add_frame(1, 256);
    // A long frame of random colours widens the codes to ten bits.
    add_frame(256, 256);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pixel_queue.size() == 0 && !in_valid_i);
    wait (byte_queue.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d pixels in %0d frames, %0d code bytes checked.", pixels_sent,
             frames_seen, bytes_seen);
    if (errors == 0 && byte_queue.size() == 0) begin
      $display("tb_gif_lzw_code_stream_encoder passed");
    end else begin
      $display("tb_gif_lzw_code_stream_encoder failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
